@@ rtl/core/mcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg
// shared types, constants and commands for the magnetometer correction block
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned ROW_W  = 48;
    localparam int unsigned GAIN_W = 24;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

    localparam logic [ROW_W-1:0]  ROW0_RESET   = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0]  ROW1_RESET   = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0]  ROW2_RESET   = 48'h1000_0000_0000;
    localparam logic [15:0]       WINDOW_RESET = 16'd1000;
    localparam logic [14:0]       LIMIT_RESET  = 15'd400;
    localparam logic [GAIN_W-1:0] GAIN_Y_RESET = 24'd13989;
    localparam logic [GAIN_W-1:0] GAIN_Z_RESET = 24'd15383;
    localparam logic [GAIN_W-1:0] GAIN_MAX     = 24'hFF_FFFF;
    localparam logic signed [15:0] MAX_RESET   = -16'sd100;
    localparam logic signed [15:0] MIN_RESET   = 16'sd100;

    // divider: 31 quotient bits, saturated to 24, over 17 bit numerator shifted by 14
    localparam int unsigned DIV_STEPS = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_CHECK,
        ST_DIV_Y,
        ST_START_Z,
        ST_DIV_Z,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;       // capture input word
        logic       mac_clear;  // start a row
        logic       mac_step;   // accumulate one product
        logic       row_done;   // finish row: round and saturate
        logic       update;     // min/max, count, completion
        logic       div_start;  // start a gain division
        logic       div_sel_z;  // 0: y span, 1: z span
        logic       div_step;   // one restoring step
        logic       div_store;  // store gain
        logic       finish;     // offsets and flags
        logic       out_load;   // present result
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic start_op;
        logic complete;
    } stat_t;

endpackage

@@ rtl/core/magnetometer_correct_and_calibrate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_correct_and_calibrate
// cross-axis correction with min/max hard-iron calibration
// ----------------------------------------------------------------------------
// sequence: a start word skips the multiply; a sample word runs through one
// shared multiplier (3 products per row, 3 rows), and a sample that ends a run
// then passes the bit-serial gain divider for each gain (31 steps, with a
// set-up and a store); one word at a time is taken, and a finished result
// waits in the output register while the next word is accepted
// reset: asynchronous active low; restores identity matrix and default gains
module magnetometer_correct_and_calibrate (
    input  logic         clk,
    input  logic         rst_n,
    // operation[0], raw_x[16:1], raw_y[32:17], raw_z[48:33]
    input  logic [55:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // corrected_x/y/z[47:0], value_x/y/z[98:48], gain_y_out[122:99],
    // gain_z_out[146:123], calibrating[147], calibration_done[148]
    output logic [151:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata
);

    mcc_pkg::ctrl_t ctrl;
    mcc_pkg::stat_t stat;
    logic           busy;
    logic [1:0]     step_cnt;
    logic           m_valid_reg;
    logic           in_fire;
    logic           out_free;

    assign s_tready  = !busy;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (ctrl.out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end
    assign m_tvalid = m_valid_reg;

    mcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy),
        .step_cnt (step_cnt)
    );

    mcc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_cnt  (step_cnt),
        .out_data  (m_tdata)
    );

endmodule

@@ rtl/core/mcc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_datapath
// matrix multiply, calibration state, gain divider and output register
// ----------------------------------------------------------------------------
module mcc_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcc_pkg::ctrl_t         ctrl,
    output mcc_pkg::stat_t         stat,
    input  logic [55:0]            in_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [47:0]            cfg_wdata,
    input  logic [1:0]             step_cnt,
    output logic [151:0]           out_data
);

    logic [47:0] row_reg [3];
    logic [15:0] window_reg;
    logic [14:0] limit_reg;

    logic        op_reg;
    logic signed [15:0] raw_reg [3];
    logic signed [35:0] acc_reg;
    logic signed [15:0] corr_reg [3];
    logic signed [15:0] max_reg [3];
    logic signed [15:0] min_reg [3];
    logic signed [15:0] offs_reg [3];
    logic [15:0] count_reg;
    logic        active_reg;
    logic        done_reg;
    logic        complete_reg;
    logic [23:0] gain_y_reg;
    logic [23:0] gain_z_reg;
    logic [1:0]  row_idx_reg;

    // divider state
    logic [16:0] den_reg;
    logic [30:0] num_reg;
    logic [17:0] rem_reg;
    logic [30:0] quo_reg;
    logic        zero_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= mcc_pkg::ROW0_RESET;
            row_reg[1] <= mcc_pkg::ROW1_RESET;
            row_reg[2] <= mcc_pkg::ROW2_RESET;
            window_reg <= mcc_pkg::WINDOW_RESET;
            limit_reg  <= mcc_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mcc_pkg::REG_ROW0:   row_reg[0] <= cfg_wdata;
                mcc_pkg::REG_ROW1:   row_reg[1] <= cfg_wdata;
                mcc_pkg::REG_ROW2:   row_reg[2] <= cfg_wdata;
                mcc_pkg::REG_WINDOW: window_reg <= cfg_wdata[15:0];
                mcc_pkg::REG_LIMIT:  limit_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // one product per cycle
    logic [47:0]        row_sel;
    logic signed [15:0] coef;
    logic signed [31:0] prod;
    logic signed [35:0] acc_next;
    assign row_sel  = row_reg[row_idx_reg];
    assign coef     = row_sel[16*step_cnt +: 16];
    assign prod     = coef * raw_reg[step_cnt];
    assign acc_next = acc_reg + 36'(prod);

    // truncate toward zero, saturate
    logic signed [35:0] acc_adj;
    logic signed [23:0] q_full;
    logic signed [15:0] q_sat;
    always_comb
    begin
        acc_adj = acc_reg + (acc_reg[35] ? 36'sd4095 : 36'sd0);
        q_full  = acc_adj[35:12];
        if (q_full > 24'sd32767)
            q_sat = 16'sh7FFF;
        else if (q_full < -24'sd32768)
            q_sat = 16'sh8000;
        else
            q_sat = q_full[15:0];
    end

    // range check and new min/max
    logic [15:0] mag [3];
    logic        in_range;
    logic signed [15:0] nmax [3];
    logic signed [15:0] nmin [3];
    always_comb
    begin
        in_range = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            mag[i]  = corr_reg[i][15] ? 16'(-corr_reg[i]) : corr_reg[i];
            if (mag[i] >= {1'b0, limit_reg})
                in_range = 1'b0;
            nmax[i] = (corr_reg[i] > max_reg[i]) ? corr_reg[i] : max_reg[i];
            nmin[i] = (corr_reg[i] < min_reg[i]) ? corr_reg[i] : min_reg[i];
        end
    end

    // spans and divider step
    logic signed [16:0] span [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            span[i] = 17'(max_reg[i]) - 17'(min_reg[i]);
    end
    logic [17:0] rem_sh;
    logic [18:0] rem_sub;
    assign rem_sh  = {rem_reg[16:0], num_reg[30]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, den_reg};

    logic [23:0] gain_q;
    always_comb
    begin
        if (zero_reg || quo_reg[30:24] != 7'd0)
            gain_q = mcc_pkg::GAIN_MAX;
        else
            gain_q = quo_reg[23:0];
    end

    logic signed [16:0] sum_h [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_h[i] = 17'(max_reg[i]) + 17'(min_reg[i]);
            sum_h[i] = sum_h[i] + (sum_h[i][16] ? 17'sd1 : 17'sd0);
        end
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                max_reg[i]  <= mcc_pkg::MAX_RESET;
                min_reg[i]  <= mcc_pkg::MIN_RESET;
                offs_reg[i] <= '0;
                raw_reg[i]  <= '0;
                corr_reg[i] <= '0;
            end
            acc_reg      <= '0;
            den_reg      <= '0;
            num_reg      <= '0;
            rem_reg      <= '0;
            quo_reg      <= '0;
            zero_reg     <= 1'b0;
            count_reg    <= '0;
            active_reg   <= 1'b0;
            done_reg     <= 1'b0;
            complete_reg <= 1'b0;
            gain_y_reg   <= mcc_pkg::GAIN_Y_RESET;
            gain_z_reg   <= mcc_pkg::GAIN_Z_RESET;
            row_idx_reg  <= '0;
            op_reg       <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                op_reg       <= in_data[0];
                raw_reg[0]   <= in_data[16:1];
                raw_reg[1]   <= in_data[32:17];
                raw_reg[2]   <= in_data[48:33];
                row_idx_reg  <= '0;
                done_reg     <= 1'b0;
                complete_reg <= 1'b0;
                if (in_data[0])
                begin
                    active_reg <= 1'b1;
                    count_reg  <= '0;
                    for (int i = 0; i < 3; i++)
                        corr_reg[i] <= '0;
                end
            end
            if (ctrl.mac_clear)
                acc_reg <= '0;
            if (ctrl.mac_step)
                acc_reg <= acc_next;
            if (ctrl.row_done)
            begin
                corr_reg[row_idx_reg] <= q_sat;
                row_idx_reg <= row_idx_reg + 2'd1;
            end
            if (ctrl.update && active_reg)
            begin
                if (in_range)
                begin
                    max_reg <= nmax;
                    min_reg <= nmin;
                end
                if (in_range && count_reg >= window_reg)
                    complete_reg <= 1'b1;
                else if (count_reg != 16'hFFFF)
                    count_reg <= count_reg + 16'd1;
            end
            if (ctrl.div_start)
            begin
                den_reg  <= ctrl.div_sel_z ? span[2] : span[1];
                num_reg  <= {span[0][16:0], 14'd0};
                zero_reg <= (ctrl.div_sel_z ? span[2] : span[1]) == 17'sd0;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end
            if (ctrl.div_step)
            begin
                num_reg <= {num_reg[29:0], 1'b0};
                if (!rem_sub[18])
                begin
                    rem_reg <= rem_sub[17:0];
                    quo_reg <= {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[29:0], 1'b0};
                end
            end
            if (ctrl.div_store)
            begin
                if (ctrl.div_sel_z)
                    gain_z_reg <= gain_q;
                else
                    gain_y_reg <= gain_q;
            end
            if (ctrl.finish)
            begin
                count_reg  <= '0;
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
            // new offsets take effect once the result with the old ones is out
            if (ctrl.out_load && done_reg)
            begin
                for (int i = 0; i < 3; i++)
                    offs_reg[i] <= sum_h[i][16:1];
            end
        end
    end

    // result word
    logic signed [16:0] val [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            val[i] = op_reg ? 17'sd0 : 17'(corr_reg[i]) - 17'(offs_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
            out_data <= {3'd0, done_reg, active_reg, gain_z_reg, gain_y_reg,
                         val[2], val[1], val[0], corr_reg[2], corr_reg[1], corr_reg[0]};
    end

    assign stat.start_op = op_reg;
    assign stat.complete = complete_reg;

endmodule

@@ rtl/core/mcc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_ctrl
// sequencer for multiply, update, gain division and output handshake
// ----------------------------------------------------------------------------
module mcc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_free,
    input  mcc_pkg::stat_t  stat,
    output mcc_pkg::ctrl_t  ctrl,
    output logic            busy,
    output logic [1:0]      step_cnt
);

    mcc_pkg::state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic [1:0] row_reg, row_next;
    logic [4:0] div_reg, div_next;
    logic       zsel_reg, zsel_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcc_pkg::ST_IDLE;
            step_reg  <= '0;
            row_reg   <= '0;
            div_reg   <= '0;
            zsel_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
            div_reg   <= div_next;
            zsel_reg  <= zsel_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        div_next   = div_reg;
        zsel_next  = zsel_reg;
        ctrl       = '0;
        ctrl.div_sel_z = zsel_reg;
        unique case (state_reg)
            mcc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    ctrl.load      = 1'b1;
                    ctrl.mac_clear = 1'b1;
                    step_next  = '0;
                    row_next   = '0;
                    state_next = mcc_pkg::ST_ROW;
                end
            end
            mcc_pkg::ST_ROW:
            begin
                if (stat.start_op)
                    state_next = mcc_pkg::ST_OUT;
                else if (step_reg == 2'd3)
                begin
                    ctrl.row_done  = 1'b1;
                    ctrl.mac_clear = 1'b1;
                    step_next = '0;
                    row_next  = row_reg + 2'd1;
                    if (row_reg == 2'd2)
                        state_next = mcc_pkg::ST_CHECK;
                end
                else
                begin
                    ctrl.mac_step = 1'b1;
                    step_next = step_reg + 2'd1;
                end
            end
            mcc_pkg::ST_CHECK:
            begin
                if (stat.complete)
                begin
                    ctrl.div_start = 1'b1;
                    ctrl.div_sel_z = 1'b0;
                    zsel_next  = 1'b0;
                    div_next   = '0;
                    state_next = mcc_pkg::ST_DIV_Y;
                end
                else if (row_reg == 2'd3)
                begin
                    ctrl.update = 1'b1;
                    row_next    = '0;
                end
                else
                    state_next = mcc_pkg::ST_OUT;
            end
            mcc_pkg::ST_DIV_Y, mcc_pkg::ST_DIV_Z:
            begin
                if (div_reg == 5'(mcc_pkg::DIV_STEPS))
                begin
                    ctrl.div_store = 1'b1;
                    if (zsel_reg)
                    begin
                        ctrl.finish = 1'b1;
                        state_next  = mcc_pkg::ST_OUT;
                    end
                    else
                    begin
                        zsel_next  = 1'b1;
                        state_next = mcc_pkg::ST_START_Z;
                    end
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                    div_next = div_reg + 5'd1;
                end
            end
            // load the z span once the y gain is stored
            mcc_pkg::ST_START_Z:
            begin
                ctrl.div_start = 1'b1;
                div_next   = '0;
                state_next = mcc_pkg::ST_DIV_Z;
            end
            mcc_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = mcc_pkg::ST_IDLE;
                end
            end
            default: state_next = mcc_pkg::ST_IDLE;
        endcase
    end

    assign busy     = (state_reg != mcc_pkg::ST_IDLE);
    assign step_cnt = step_reg;

endmodule

@@ rtl/core/mcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_assertions
// port-level checks over time for the magnetometer block
// ----------------------------------------------------------------------------
module mcc_assertions (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata
);

    // a result word holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no new word taken right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // done implies the run has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[148] |-> !m_tdata[147])
        else $error("done while still calibrating");

    // a result only follows work in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready, 1))
        else $error("result without work");

endmodule

bind magnetometer_correct_and_calibrate mcc_assertions u_mcc_assertions (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/mcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_checker
// watches the input, config and result channels of the magnetometer block,
// predicts each result from its own copy of the block state and compares
// ----------------------------------------------------------------------------
module mcc_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [55:0]  s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_wdata,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic              done;
        logic              cal;
        logic [23:0]       gz;
        logic [23:0]       gy;
        logic signed [16:0] vz;
        logic signed [16:0] vy;
        logic signed [16:0] vx;
        logic signed [15:0] cz;
        logic signed [15:0] cy;
        logic signed [15:0] cx;
    } mag_result_t;

    logic [47:0] rows [3];
    logic [15:0] win;
    logic [14:0] lim;
    int          hi [3];
    int          lo [3];
    int          ofs [3];
    int          cnt;
    bit          active;
    logic [23:0] gain_y, gain_z;
    mag_result_t expected_q [$];

    // signed Q4.12 row dot product, truncated and saturated
    function automatic int row_dot(logic [47:0] row, int a [3]);
        longint sum;
        longint q;
        sum = 0;
        for (int c = 0; c < 3; c++)
            sum += longint'($signed(row[16*c +: 16])) * a[c];
        q = sum / 4096;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic logic [23:0] span_ratio(int num, int den);
        longint q;
        if (den == 0) return mcc_pkg::GAIN_MAX;
        q = (longint'(num) * 16384) / den;
        if (q < 0) return '0;
        if (q > 16777215) return mcc_pkg::GAIN_MAX;
        return q[23:0];
    endfunction

    function automatic mag_result_t predict_sample(logic [55:0] w);
        mag_result_t r;
        int raw [3];
        int cor [3];
        bit ok;
        bit done;
        r = '0;
        done = 0;
        if (w[0])
        begin
            active = 1;
            cnt = 0;
        end
        else
        begin
            raw[0] = $signed(w[16:1]);
            raw[1] = $signed(w[32:17]);
            raw[2] = $signed(w[48:33]);
            for (int a = 0; a < 3; a++) cor[a] = row_dot(rows[a], raw);
            r.cx = 16'(cor[0]); r.cy = 16'(cor[1]); r.cz = 16'(cor[2]);
            r.vx = 17'(cor[0] - ofs[0]);
            r.vy = 17'(cor[1] - ofs[1]);
            r.vz = 17'(cor[2] - ofs[2]);
            if (active)
            begin
                ok = 1;
                for (int a = 0; a < 3; a++)
                    if ((cor[a] < 0 ? -cor[a] : cor[a]) >= int'(lim)) ok = 0;
                if (ok)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        if (cor[a] > hi[a]) hi[a] = cor[a];
                        if (cor[a] < lo[a]) lo[a] = cor[a];
                    end
                    if (cnt >= int'(win))
                    begin
                        for (int a = 0; a < 3; a++) ofs[a] = (hi[a] + lo[a]) / 2;
                        gain_y = span_ratio(hi[0] - lo[0], hi[1] - lo[1]);
                        gain_z = span_ratio(hi[0] - lo[0], hi[2] - lo[2]);
                        cnt = 0;
                        active = 0;
                        done = 1;
                    end
                end
                if (!done && cnt < 65535) cnt++;
            end
        end
        r.gy = gain_y;
        r.gz = gain_z;
        r.cal = active;
        r.done = done;
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        mag_result_t got, want;
        if (!rst_n)
        begin
            rows[0] = mcc_pkg::ROW0_RESET;
            rows[1] = mcc_pkg::ROW1_RESET;
            rows[2] = mcc_pkg::ROW2_RESET;
            win = mcc_pkg::WINDOW_RESET;
            lim = mcc_pkg::LIMIT_RESET;
            for (int a = 0; a < 3; a++)
            begin
                hi[a] = -100; lo[a] = 100; ofs[a] = 0;
            end
            cnt = 0;
            active = 0;
            gain_y = mcc_pkg::GAIN_Y_RESET;
            gain_z = mcc_pkg::GAIN_Z_RESET;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mcc_pkg::REG_ROW0:   rows[0] = cfg_wdata;
                    mcc_pkg::REG_ROW1:   rows[1] = cfg_wdata;
                    mcc_pkg::REG_ROW2:   rows[2] = cfg_wdata;
                    mcc_pkg::REG_WINDOW: win = cfg_wdata[15:0];
                    mcc_pkg::REG_LIMIT:  lim = cfg_wdata[14:0];
                    default:             ;
                endcase
            end
            // result word against oldest expectation
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[148:0];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz)
                    begin
                        $display("%0t: corrected expected %0d %0d %0d actual %0d %0d %0d",
                                 $time, want.cx, want.cy, want.cz, got.cx, got.cy, got.cz);
                        errors++;
                    end
                    if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz)
                    begin
                        $display("%0t: value expected %0d %0d %0d actual %0d %0d %0d",
                                 $time, want.vx, want.vy, want.vz, got.vx, got.vy, got.vz);
                        errors++;
                    end
                    if (got.gy !== want.gy || got.gz !== want.gz)
                    begin
                        $display("%0t: gains expected %0d %0d actual %0d %0d",
                                 $time, want.gy, want.gz, got.gy, got.gz);
                        errors++;
                    end
                    if (got.cal !== want.cal || got.done !== want.done)
                    begin
                        $display("%0t: flags expected cal %b done %b actual cal %b done %b",
                                 $time, want.cal, want.done, got.cal, got.done);
                        errors++;
                    end
                end
            end
            // input word
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_sample(s_tdata));
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the magnetometer correction block: directed corner words,
// calibration runs with random samples, random stalls on both sides
// ----------------------------------------------------------------------------
module tb;

    logic         clk;
    logic         rst_n;
    logic [55:0]  s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [47:0]  cfg_wdata;
    int           errors;
    int           pending;
    int           cycles;
    bit           rx_calm;
    bit           tx_calm;
    bit           hold_rx;

    magnetometer_correct_and_calibrate u_top (.*);

    mcc_checker u_chk (.*);

    initial clk = 0;
    always #2 clk = ~clk;

    // run limit
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 900000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random back-pressure, long hold when asked
    initial m_tready = 0;
    always @(negedge clk)
    begin
        if (hold_rx) m_tready <= 0;
        else if (rx_calm) m_tready <= 1;
        else m_tready <= ($urandom_range(99) >= 30);
    end

    // input words are driven with blocking writes at the falling edge
    task automatic send_word(input bit op, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        while (!tx_calm && $urandom_range(99) < 30)
        begin
            s_tvalid = 0;
            @(negedge clk);
        end
        s_tvalid = 1;
        s_tdata = {7'd0, z, y, x, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic logic [15:0] near(int lim);
        return 16'($urandom_range(2 * lim) - lim);
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(16'hffff));
    endfunction

    function automatic logic [47:0] rand_row();
        return {rnd16(), rnd16(), rnd16()};
    endfunction

    initial
    begin
        int lim;
        int n;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_valid = 0;
        cfg_index = mcc_pkg::REG_ROW0;
        cfg_wdata = '0;
        rx_calm = 0;
        tx_calm = 0;
        hold_rx = 0;
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: extremes with identity matrix, then a tiny run
        send_word(1'b0, 16'h7fff, 16'h8000, 16'h0000);
        send_word(1'b0, 16'h8000, 16'h7fff, 16'hffff);
        send_word(1'b0, 16'hffff, 16'hffff, 16'h7fff);
        send_word(1'b1, 16'h1234, 16'h5678, 16'h9abc);
        send_word(1'b0, 16'd5, 16'd5, 16'd5);
        send_word(1'b0, 16'd500, 16'd0, 16'd0);
        write_reg(mcc_pkg::REG_WINDOW, 48'd0);
        send_word(1'b0, 16'd10, -16'd20, 16'd30);
        // zero span on y and z
        write_reg(mcc_pkg::REG_WINDOW, 48'd2);
        send_word(1'b1, 16'd0, 16'd0, 16'd0);
        send_word(1'b1, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 3; i++) send_word(1'b0, 16'(150 * i - 150), 16'd0, 16'd0);
        // saturating matrix, window and limit extremes
        write_reg(mcc_pkg::REG_ROW0, 48'h7fff_7fff_7fff);
        write_reg(mcc_pkg::REG_ROW1, 48'h8000_8000_8000);
        write_reg(mcc_pkg::REG_ROW2, 48'hffff_0001_8000);
        send_word(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_word(1'b0, 16'h8000, 16'h8000, 16'h8000);
        send_word(1'b0, 16'h8000, 16'h7fff, 16'h0001);
        write_reg(mcc_pkg::REG_LIMIT, 48'h7fff);
        write_reg(mcc_pkg::REG_WINDOW, 48'hffff);
        send_word(1'b1, 16'd0, 16'd0, 16'd0);
        send_word(1'b0, 16'h1000, 16'hf000, 16'h0100);

        // back-pressure: receiver stops while the sender keeps offering
        fork
            begin
                hold_rx = 1;
                repeat (400) @(negedge clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 12; i++)
                send_word(1'b0, rnd16(), rnd16(), rnd16());
        join

        // random phases of calibration runs
        n = 0;
        for (int ph = 0; n < 1380; ph++)
        begin
            rx_calm = (ph % 7 == 3);
            tx_calm = rx_calm;
            if (ph % 3 == 0)
                write_reg(mcc_pkg::REG_ROW0, (ph % 2) ? rand_row() : mcc_pkg::ROW0_RESET);
            else if (ph % 3 == 1)
                write_reg(mcc_pkg::REG_ROW1, (ph % 2) ? rand_row() : mcc_pkg::ROW1_RESET);
            else
                write_reg(mcc_pkg::REG_ROW2, (ph % 2) ? rand_row() : mcc_pkg::ROW2_RESET);
            lim = (ph % 5 == 0) ? 32767 : $urandom_range(50, 2000);
            write_reg(mcc_pkg::REG_LIMIT, 48'(lim));
            write_reg(mcc_pkg::REG_WINDOW, 48'($urandom_range(0, 25)));
            send_word(1'b1, rnd16(), rnd16(), rnd16());
            n++;
            for (int i = 0; i < 40; i++)
            begin
                if ($urandom_range(99) < 3)
                    send_word(1'b1, rnd16(), rnd16(), rnd16());
                else if ($urandom_range(99) < 80)
                    send_word(1'b0, near(lim), near(lim), near(lim));
                else
                    send_word(1'b0, rnd16(), rnd16(), rnd16());
                n++;
            end
        end
        rx_calm = 0;
        tx_calm = 0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
